// File: src/bts_pkg.sv
package bts_pkg;

   // Store geometry and texel width.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 512;
   localparam int VALUE_BITS = 16;

   localparam int X_BITS = $clog2(MAX_WIDTH);
   localparam int Y_BITS = $clog2(MAX_HEIGHT);

   // Field widths of the request and response items.
   localparam int TEXEL_X_W     = 10;
   localparam int TEXEL_Y_W     = 9;
   localparam int TEXEL_VALUE_W = 16;
   localparam int COORD_W       = 18;
   localparam int SAMPLE_W      = 16;
   localparam int FRAC_BITS     = 16;

   // Bit positions of the fields inside req_tdata.
   localparam int TX_LSB     = 0;
   localparam int TY_LSB     = TX_LSB + TEXEL_X_W;
   localparam int TV_LSB     = TY_LSB + TEXEL_Y_W;
   localparam int CU_LSB     = TV_LSB + TEXEL_VALUE_W;
   localparam int CV_LSB     = CU_LSB + COORD_W;
   localparam int REQ_BITS   = CV_LSB + COORD_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SAMPLE_W + 7) / 8) * 8;

   // Action codes carried in req_tuser.
   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   // Register file.
   localparam int CFG_WIDTH_W   = 11;
   localparam int CFG_HEIGHT_W  = 10;
   localparam int CSR_DATA_W    = 11;
   localparam int CSR_INDEX_W   = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;
   localparam int CFG_WIDTH_RESET  = 640;
   localparam int CFG_HEIGHT_RESET = 480;

   // Coordinate scaling: Q1.16 coordinate times (extent - 1).
   localparam int PROD_X_W = COORD_W + X_BITS + 1;
   localparam int PROD_Y_W = COORD_W + Y_BITS + 1;
   localparam int IX_W     = PROD_X_W - FRAC_BITS;
   localparam int IY_W     = PROD_Y_W - FRAC_BITS;

   // Texel store split into 2x2 banks by the parity of x and y.
   localparam int NUM_BANKS  = 4;
   localparam int BANK_AW    = (X_BITS - 1) + (Y_BITS - 1);
   localparam int BANK_DEPTH = 1 << BANK_AW;

   // Blend products: signed difference times unsigned fraction.
   localparam int BLEND_PROD_W = VALUE_BITS + FRAC_BITS + 2;

   // Result buffer.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

   typedef logic [1:0] bank_sel_type;

   typedef struct packed {
      logic                  we;
      logic [BANK_AW-1:0]    addr;
      logic [VALUE_BITS-1:0] wdata;
   } bank_req_type;

   typedef struct packed {
      logic                 valid;
      bank_sel_type         sel_a;
      bank_sel_type         sel_b;
      bank_sel_type         sel_c;
      bank_sel_type         sel_d;
      logic [FRAC_BITS-1:0] fx;
      logic [FRAC_BITS-1:0] fy;
   } tap_ctl_type;

endpackage

// File: src/bilinear_texel_sampler.sv
// Bilinear texel sampler with clamp-to-edge addressing over a 1024 x 512
// single-channel image of 16-bit texels.
//
// Requests arrive on the req_ stream. req_tuser selects the action: a write
// transfer stores one texel at (texel_x, texel_y) and produces no response;
// a sample transfer carries Q1.16 coordinates u, v and produces exactly one
// response on the rsp_ stream, in request order. Image size is set through
// the csr_ write port (index 0 width, index 1 height); the user must write
// it only while no request is outstanding, which the block does not enforce.
//
// After its request transfer, a sample passes in order through the
// input register, the coordinate multiply, clamp and bank addressing with
// the texel read, three blend stages, then the response buffer. The store is
// split into four banks by the parity of x and y, so the four neighbors come
// out together and a request is taken every cycle while req_tready is high.
// At most 8 samples are outstanding, which the 8-entry response buffer always
// holds; when the receiver stalls, req_tready drops once 8 are outstanding
// and rises in the cycle after a response transfer. Reset empties the
// pipeline and response buffer and sets the image to 640 x 480; texels are
// not cleared and must be written before any sample reads them.
module bilinear_texel_sampler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // texel_x, texel_y, texel_value, coord_u, coord_v, zero fill
   input  logic [bts_pkg::REQ_DATA_W-1:0]       req_tdata,
   // action
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // sample_value
   output logic [bts_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                 csr_wr_en,
   input  logic [bts_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import bts_pkg::*;

   logic                  req_xfer, rsp_xfer, sample_xfer;
   logic [CREDIT_W-1:0]   outstanding_ff, outstanding_in;
   logic [X_BITS-1:0]     width_m1_ff, width_m1_in;
   logic [Y_BITS-1:0]     height_m1_ff, height_m1_in;
   logic [CFG_WIDTH_W-1:0]  cfg_w;
   logic [CFG_HEIGHT_W-1:0] cfg_h;

   bank_req_type [NUM_BANKS-1:0]                  bank_req;
   logic [NUM_BANKS-1:0][VALUE_BITS-1:0]          bank_rdata;
   tap_ctl_type                                   tap;
   logic                                          push_valid;
   logic [SAMPLE_W-1:0]                           push_value;
   logic [SAMPLE_W-1:0]                           rsp_value;

   // Credit count of sample requests whose response has not yet been taken.
   assign req_tready  = (outstanding_ff < CREDIT_W'(FIFO_DEPTH));
   assign req_xfer    = req_tvalid && req_tready;
   assign sample_xfer = req_xfer && (req_tuser == ACTION_SAMPLE);
   assign rsp_xfer    = rsp_tvalid && rsp_tready;
   assign outstanding_in = outstanding_ff + CREDIT_W'(sample_xfer) - CREDIT_W'(rsp_xfer);

   // The registers keep extent - 1, with zero read as one and oversize
   // values saturated to the store size.
   assign cfg_w = csr_wdata[CFG_WIDTH_W-1:0];
   assign cfg_h = csr_wdata[CFG_HEIGHT_W-1:0];

   always_comb begin
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               priority if (cfg_w == '0) begin
                  width_m1_in = '0;
               end else if (cfg_w > CFG_WIDTH_W'(MAX_WIDTH)) begin
                  width_m1_in = X_BITS'(MAX_WIDTH - 1);
               end else begin
                  width_m1_in = X_BITS'(cfg_w - 1'b1);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               priority if (cfg_h == '0) begin
                  height_m1_in = '0;
               end else if (cfg_h > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
                  height_m1_in = Y_BITS'(MAX_HEIGHT - 1);
               end else begin
                  height_m1_in = Y_BITS'(cfg_h - 1'b1);
               end
            end
            default: begin
               width_m1_in  = width_m1_ff;
               height_m1_in = height_m1_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         width_m1_ff    <= X_BITS'(CFG_WIDTH_RESET - 1);
         height_m1_ff   <= Y_BITS'(CFG_HEIGHT_RESET - 1);
      end else begin
         outstanding_ff <= outstanding_in;
         width_m1_ff    <= width_m1_in;
         height_m1_ff   <= height_m1_in;
      end
   end

   bts_coord u_coord (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_xfer),
      .item_action (req_tuser),
      .texel_x     (req_tdata[TX_LSB +: TEXEL_X_W]),
      .texel_y     (req_tdata[TY_LSB +: TEXEL_Y_W]),
      .texel_value (req_tdata[TV_LSB +: TEXEL_VALUE_W]),
      .coord_u     (req_tdata[CU_LSB +: COORD_W]),
      .coord_v     (req_tdata[CV_LSB +: COORD_W]),
      .width_m1    (width_m1_ff),
      .height_m1   (height_m1_ff),
      .bank_req    (bank_req),
      .tap         (tap)
   );

   // Bank index is {y parity, x parity}; each bank holds every other texel
   // of every other row.
   for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
      bts_ram #(
         .WIDTH (VALUE_BITS),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (bank_req[g].we),
         .addr  (bank_req[g].addr),
         .wdata (bank_req[g].wdata),
         .rdata (bank_rdata[g])
      );
   end

   bts_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .tap        (tap),
      .bank_rdata (bank_rdata),
      .push_valid (push_valid),
      .push_value (push_value)
   );

   bts_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_value),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_value)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_value);

endmodule

// File: src/bts_ram.sv
module bts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/bts_coord.sv
module bts_coord (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    item_valid,
   input  logic                                    item_action,
   input  logic [bts_pkg::TEXEL_X_W-1:0]           texel_x,
   input  logic [bts_pkg::TEXEL_Y_W-1:0]           texel_y,
   input  logic [bts_pkg::TEXEL_VALUE_W-1:0]       texel_value,
   input  logic [bts_pkg::COORD_W-1:0]             coord_u,
   input  logic [bts_pkg::COORD_W-1:0]             coord_v,
   input  logic [bts_pkg::X_BITS-1:0]              width_m1,
   input  logic [bts_pkg::Y_BITS-1:0]              height_m1,
   output bts_pkg::bank_req_type [bts_pkg::NUM_BANKS-1:0] bank_req,
   output bts_pkg::tap_ctl_type                    tap
);

   import bts_pkg::*;

   // Input register.
   logic                     v0_ff, act0_ff;
   logic [TEXEL_X_W-1:0]     tx0_ff;
   logic [TEXEL_Y_W-1:0]     ty0_ff;
   logic [TEXEL_VALUE_W-1:0] tv0_ff;
   logic [COORD_W-1:0]       cu0_ff, cv0_ff;

   // Scaled coordinates.
   logic                       v1_ff, act1_ff;
   logic [TEXEL_X_W-1:0]       tx1_ff;
   logic [TEXEL_Y_W-1:0]       ty1_ff;
   logic [TEXEL_VALUE_W-1:0]   tv1_ff;
   logic signed [PROD_X_W-1:0] px1_ff, px_in;
   logic signed [PROD_Y_W-1:0] py1_ff, py_in;

   logic signed [IX_W-1:0] ix, ix_p1;
   logic signed [IY_W-1:0] iy, iy_p1;
   logic [X_BITS-1:0]      x0, x1;
   logic [Y_BITS-1:0]      y0, y1;
   logic [X_BITS-1:0]      xsel [2];
   logic [Y_BITS-1:0]      ysel [2];
   logic                   wr_ok;
   bank_sel_type           wr_bank;
   tap_ctl_type            tap_ff, tap_in;

   assign px_in = $signed(cu0_ff) * $signed({1'b0, width_m1});
   assign py_in = $signed(cv0_ff) * $signed({1'b0, height_m1});

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         tap_ff.valid <= 1'b0;
      end else begin
         v0_ff        <= item_valid;
         v1_ff        <= v0_ff;
         tap_ff.valid <= tap_in.valid;
      end
      act0_ff <= item_action;
      tx0_ff  <= texel_x;
      ty0_ff  <= texel_y;
      tv0_ff  <= texel_value;
      cu0_ff  <= coord_u;
      cv0_ff  <= coord_v;
      act1_ff <= act0_ff;
      tx1_ff  <= tx0_ff;
      ty1_ff  <= ty0_ff;
      tv1_ff  <= tv0_ff;
      px1_ff  <= px_in;
      py1_ff  <= py_in;
      tap_ff.sel_a <= tap_in.sel_a;
      tap_ff.sel_b <= tap_in.sel_b;
      tap_ff.sel_c <= tap_in.sel_c;
      tap_ff.sel_d <= tap_in.sel_d;
      tap_ff.fx    <= tap_in.fx;
      tap_ff.fy    <= tap_in.fy;
   end

   // The upper bits of the two's complement product are floor(p / 65536).
   assign ix    = px1_ff[PROD_X_W-1:FRAC_BITS];
   assign iy    = py1_ff[PROD_Y_W-1:FRAC_BITS];
   assign ix_p1 = ix + IX_W'(1);
   assign iy_p1 = iy + IY_W'(1);

   // Clamp-to-edge addressing of the two columns and the two rows.
   always_comb begin
      priority if (ix[IX_W-1]) begin
         x0 = '0;
      end else if (ix > $signed({{(IX_W-X_BITS){1'b0}}, width_m1})) begin
         x0 = width_m1;
      end else begin
         x0 = ix[X_BITS-1:0];
      end
      priority if (ix_p1[IX_W-1]) begin
         x1 = '0;
      end else if (ix_p1 > $signed({{(IX_W-X_BITS){1'b0}}, width_m1})) begin
         x1 = width_m1;
      end else begin
         x1 = ix_p1[X_BITS-1:0];
      end
      priority if (iy[IY_W-1]) begin
         y0 = '0;
      end else if (iy > $signed({{(IY_W-Y_BITS){1'b0}}, height_m1})) begin
         y0 = height_m1;
      end else begin
         y0 = iy[Y_BITS-1:0];
      end
      priority if (iy_p1[IY_W-1]) begin
         y1 = '0;
      end else if (iy_p1 > $signed({{(IY_W-Y_BITS){1'b0}}, height_m1})) begin
         y1 = height_m1;
      end else begin
         y1 = iy_p1[Y_BITS-1:0];
      end
   end

   // The two columns are either equal or adjacent, so each parity bank
   // sees at most one distinct column; the same holds for rows.
   always_comb begin
      xsel[0] = x0[0] ? x1 : x0;
      xsel[1] = x0[0] ? x0 : x1;
      ysel[0] = y0[0] ? y1 : y0;
      ysel[1] = y0[0] ? y0 : y1;
   end

   assign wr_ok   = ({1'b0, tx1_ff} < (TEXEL_X_W+1)'(MAX_WIDTH)) &&
                    ({1'b0, ty1_ff} < (TEXEL_Y_W+1)'(MAX_HEIGHT));
   assign wr_bank = {ty1_ff[0], tx1_ff[0]};

   // Writes and reads share one bank port; only one item is in this stage
   // at a time, so a write always lands before any later read of the entry.
   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         if (act1_ff == ACTION_WRITE) begin
            bank_req[b].we   = v1_ff && wr_ok && (wr_bank == bank_sel_type'(b));
            bank_req[b].addr = {ty1_ff[Y_BITS-1:1], tx1_ff[X_BITS-1:1]};
         end else begin
            bank_req[b].we   = 1'b0;
            bank_req[b].addr = {ysel[b/2][Y_BITS-1:1], xsel[b%2][X_BITS-1:1]};
         end
         bank_req[b].wdata = tv1_ff[VALUE_BITS-1:0];
      end
   end

   always_comb begin
      tap_in.valid = v1_ff && (act1_ff == ACTION_SAMPLE);
      tap_in.sel_a = {y0[0], x0[0]};
      tap_in.sel_b = {y0[0], x1[0]};
      tap_in.sel_c = {y1[0], x0[0]};
      tap_in.sel_d = {y1[0], x1[0]};
      tap_in.fx    = px1_ff[FRAC_BITS-1:0];
      tap_in.fy    = py1_ff[FRAC_BITS-1:0];
   end

   assign tap = tap_ff;

endmodule

// File: src/bts_blend.sv
module bts_blend (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  bts_pkg::tap_ctl_type                                   tap,
   input  logic [bts_pkg::NUM_BANKS-1:0][bts_pkg::VALUE_BITS-1:0] bank_rdata,
   output logic                                                   push_valid,
   output logic [bts_pkg::SAMPLE_W-1:0]                           push_value
);

   import bts_pkg::*;

   logic [VALUE_BITS-1:0]         a, b, c, d;
   logic signed [VALUE_BITS:0]    diff_ab, diff_cd, diff_v;
   logic signed [BLEND_PROD_W-1:0] pt_in, pb_in, pm_in;

   logic                           v3_ff, v4_ff, v5_ff;
   logic signed [BLEND_PROD_W-1:0] pt3_ff, pb3_ff, pm5_ff;
   logic [VALUE_BITS-1:0]          a3_ff, c3_ff, top4_ff, bot4_ff, top5_ff;
   logic [FRAC_BITS-1:0]           fy3_ff, fy4_ff;

   logic signed [VALUE_BITS+1:0] top_sum, bot_sum, fin_sum;
   logic [VALUE_BITS-1:0]        top_in, bot_in;

   // Horizontal blend products of the top and bottom texel pairs.
   assign a       = bank_rdata[tap.sel_a];
   assign b       = bank_rdata[tap.sel_b];
   assign c       = bank_rdata[tap.sel_c];
   assign d       = bank_rdata[tap.sel_d];
   assign diff_ab = $signed({1'b0, b}) - $signed({1'b0, a});
   assign diff_cd = $signed({1'b0, d}) - $signed({1'b0, c});
   assign pt_in   = diff_ab * $signed({1'b0, tap.fx});
   assign pb_in   = diff_cd * $signed({1'b0, tap.fx});

   // a + floor(product / 65536); the blend stays between its two texels.
   assign top_sum = $signed({2'b00, a3_ff}) + $signed(pt3_ff[BLEND_PROD_W-1:FRAC_BITS]);
   assign bot_sum = $signed({2'b00, c3_ff}) + $signed(pb3_ff[BLEND_PROD_W-1:FRAC_BITS]);
   assign top_in  = top_sum[VALUE_BITS-1:0];
   assign bot_in  = bot_sum[VALUE_BITS-1:0];

   // Vertical blend between the two rows.
   assign diff_v  = $signed({1'b0, bot4_ff}) - $signed({1'b0, top4_ff});
   assign pm_in   = diff_v * $signed({1'b0, fy4_ff});
   assign fin_sum = $signed({2'b00, top5_ff}) + $signed(pm5_ff[BLEND_PROD_W-1:FRAC_BITS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v3_ff <= tap.valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      pt3_ff  <= pt_in;
      pb3_ff  <= pb_in;
      a3_ff   <= a;
      c3_ff   <= c;
      fy3_ff  <= tap.fy;
      top4_ff <= top_in;
      bot4_ff <= bot_in;
      fy4_ff  <= fy3_ff;
      pm5_ff  <= pm_in;
      top5_ff <= top4_ff;
   end

   assign push_valid = v5_ff;
   assign push_value = SAMPLE_W'(fin_sum[VALUE_BITS-1:0]);

endmodule

// File: src/bts_fifo.sv
module bts_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [bts_pkg::SAMPLE_W-1:0]  push_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [bts_pkg::SAMPLE_W-1:0]  out_data
);

   import bts_pkg::*;

   logic [SAMPLE_W-1:0] mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CREDIT_W-1:0] count_ff, count_in;
   logic                pop;

   // Space is guaranteed by the credit check at the request side.
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CREDIT_W'(push) - CREDIT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
